// ----- src/wds_pkg.sv -----
// Package for the windowed duration statistics block.
// Holds the command codes and the transfer structs of the request and response channels.
// No dependencies.
package wds_pkg;

   localparam int TIME_W  = 48;
   localparam int WIN_W   = 24;
   localparam int SUM_W   = 56;
   localparam int COUNT_W = 9;
   localparam int LIM_W   = 45;
   localparam int MS_W    = 20;

   // Nanoseconds in one millisecond
   localparam logic [MS_W-1:0] NS_PER_MS = MS_W'(1000000);

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_END   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [TIME_W-1:0] time_ns;
      logic [WIN_W-1:0]  window_ms;
   } req_type;

   typedef struct packed {
      logic               has_samples;
      logic [TIME_W-1:0]  window_start_ns;
      logic [TIME_W-1:0]  window_stop_ns;
      logic [SUM_W-1:0]   sum_ns;
      logic [COUNT_W-1:0] sample_count;
      logic [TIME_W-1:0]  window_max_ns;
      logic [TIME_W-1:0]  window_min_ns;
      logic [TIME_W-1:0]  all_time_max_ns;
      logic [TIME_W-1:0]  all_time_min_ns;
   } rsp_type;

   // Control of the duration accumulator
   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctrl_type;

endpackage

// ----- src/wds_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wds_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/wds_qualify.sv -----
// Window test for one stored sample: is its start or stop age inside the query window.
// Depends on wds_pkg.
module wds_qualify (
   input  logic [wds_pkg::TIME_W-1:0] now,
   input  logic [wds_pkg::TIME_W-1:0] start_ts,
   input  logic [wds_pkg::TIME_W-1:0] stop_ts,
   input  logic                       win_pos,
   input  logic [wds_pkg::LIM_W-1:0]  lim_lo,
   input  logic [wds_pkg::LIM_W-1:0]  lim_hi,
   output logic                       hit
);
   import wds_pkg::*;

   localparam logic signed [TIME_W:0] NEG_MS = -$signed({1'b0, TIME_W'(NS_PER_MS)});

   logic [TIME_W:0] d_start;
   logic [TIME_W:0] d_stop;
   logic            start_in;
   logic            stop_in;

   assign d_start = {1'b0, now} - {1'b0, start_ts};
   assign d_stop  = {1'b0, now} - {1'b0, stop_ts};

   // Start age in whole ms below the window; negative ages truncate towards zero
   always_comb begin
      if (d_start[TIME_W]) begin
         start_in = win_pos || ($signed(d_start) <= NEG_MS);
      end else begin
         start_in = d_start[TIME_W-1:0] < TIME_W'(lim_lo);
      end
   end

   // Stop age in whole ms not above the window
   assign stop_in = d_stop[TIME_W] || (d_stop[TIME_W-1:0] < TIME_W'(lim_hi));

   assign hit = start_in || stop_in;

endmodule

// ----- src/wds_accum.sv -----
// Running sum (saturating), maximum and minimum of durations over one query window.
// Depends on wds_pkg.
module wds_accum (
   input  logic                       clock,
   input  wds_pkg::acc_ctrl_type      ctrl,
   input  logic [wds_pkg::TIME_W-1:0] dur,
   output logic [wds_pkg::SUM_W-1:0]  sum,
   output logic [wds_pkg::TIME_W-1:0] max_dur,
   output logic [wds_pkg::TIME_W-1:0] min_dur
);
   import wds_pkg::*;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [TIME_W-1:0] max_ff, max_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic [SUM_W:0]    total;

   assign total = {1'b0, sum_ff} + (SUM_W + 1)'(dur);

   // Clear on a new window, otherwise fold in the next duration
   always_comb begin
      sum_in = sum_ff;
      max_in = max_ff;
      min_in = min_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         max_in = '0;
         min_in = '1;
      end else if (ctrl.add) begin
         sum_in = total[SUM_W] ? '1 : total[SUM_W-1:0];
         if (dur > max_ff) begin
            max_in = dur;
         end
         if (dur < min_ff) begin
            min_in = dur;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      max_ff <= max_in;
      min_ff <= min_in;
   end

   assign sum     = sum_ff;
   assign max_dur = max_ff;
   assign min_dur = min_ff;

endmodule

// ----- src/windowed_duration_statistics.sv -----
// Windowed duration statistics: latency monitor over a ring of the last DEPTH samples.
// Depends on wds_pkg, wds_ram, wds_qualify and wds_accum.
//
// Begin (cmd 0) records a start time without raising busy; end (cmd 1) records the stop time
// and duration and holds busy in ST_END while the start entry is read back. A query
// (cmd 2) walks the sample memories twice, one entry per cycle: first from the oldest sample
// until the first one inside the window, then from there to the newest, summing durations.
// Busy stays high through both walks and the ST_DONE state after them, each walk covering
// at most the samples held (at most DEPTH); the response is on the ports in the first cycle
// with busy low again. A query on an empty ring answers in the cycle after it is taken
// without raising busy. Each response is marked by a one-cycle rsp_strobe and stays on
// rsp_data until the next one; the receiver cannot stall it. Start
// times sit in one RAM, stop times and durations in a second; neither needs clearing after
// reset.
module windowed_duration_statistics #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wds_pkg::req_type req_data,
   output logic             rsp_strobe,
   output wds_pkg::rsp_type rsp_data
);
   import wds_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_END    = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_SUM    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     widx_ff, widx_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [TIME_W-1:0] ever_max_ff, ever_max_in;
   logic [TIME_W-1:0] ever_min_ff, ever_min_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [LIM_W-1:0]  lim_lo_ff, lim_lo_in;
   logic [LIM_W-1:0]  lim_hi_ff, lim_hi_in;
   logic              win_pos_ff, win_pos_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              ev_valid_ff, ev_valid_in;
   logic [AW-1:0]     ev_ptr_ff, ev_ptr_in;
   logic [CW-1:0]     ev_cnt_ff, ev_cnt_in;
   logic [CW-1:0]     off_ff, off_in;
   logic [TIME_W-1:0] win_start_ff, win_start_in;
   logic [TIME_W-1:0] last_stop_ff, last_stop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              full;
   logic              ev_last;
   logic              hit;
   logic [TIME_W-1:0] start_rd;
   logic [AW-1:0]     start_raddr;
   logic [2*TIME_W-1:0] hist_rd;
   logic              hist_we;
   logic [TIME_W-1:0] dur_new;
   logic [TIME_W-1:0] acc_sum_unused_hi;
   logic [SUM_W-1:0]  acc_sum;
   logic [TIME_W-1:0] acc_max;
   logic [TIME_W-1:0] acc_min;
   acc_ctrl_type      acc_ctrl;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign full    = (fill_ff == CW'(DEPTH));
   assign ev_last = (ev_cnt_ff == CW'(count_ff - 1'b1));
   assign acc_sum_unused_hi = '0;

   // Start times: written on a begin transfer, read for an end or during the search
   assign start_raddr = (state_ff == ST_SEARCH) ? ptr_ff : widx_ff;

   wds_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_start_ram (
      .clock   (clock),
      .wr_en   (accept && (req_data.cmd == CMD_BEGIN)),
      .wr_addr (widx_ff),
      .wr_data (req_data.time_ns),
      .rd_addr (start_raddr),
      .rd_data (start_rd)
   );

   // Stop times and durations, written together when a sample ends
   assign hist_we = (state_ff == ST_END);
   assign dur_new = (now_ff >= start_rd) ? now_ff - start_rd : '0;

   wds_ram #(.WIDTH(2 * TIME_W), .DEPTH(DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (widx_ff),
      .wr_data ({now_ff, dur_new}),
      .rd_addr (ptr_ff),
      .rd_data (hist_rd)
   );

   wds_qualify u_qualify (
      .now      (now_ff),
      .start_ts (start_rd),
      .stop_ts  (hist_rd[2*TIME_W-1:TIME_W]),
      .win_pos  (win_pos_ff),
      .lim_lo   (lim_lo_ff),
      .lim_hi   (lim_hi_ff),
      .hit      (hit)
   );

   wds_accum u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .dur     (hist_rd[TIME_W-1:0] | acc_sum_unused_hi),
      .sum     (acc_sum),
      .max_dur (acc_max),
      .min_dur (acc_min)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      fill_in      = fill_ff;
      ever_max_in  = ever_max_ff;
      ever_min_in  = ever_min_ff;
      now_in       = now_ff;
      lim_lo_in    = lim_lo_ff;
      lim_hi_in    = lim_hi_ff;
      win_pos_in   = win_pos_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      ev_valid_in  = ev_valid_ff;
      ev_ptr_in    = ev_ptr_ff;
      ev_cnt_in    = ev_cnt_ff;
      off_in       = off_ff;
      win_start_in = win_start_ff;
      last_stop_in = last_stop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      acc_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req_data.time_ns;
               unique case (req_data.cmd)
                  CMD_END: begin
                     state_in = ST_END;
                  end
                  CMD_QUERY: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                     end else begin
                        lim_lo_in   = LIM_W'(req_data.window_ms) * LIM_W'(NS_PER_MS);
                        lim_hi_in   = (LIM_W'(req_data.window_ms) + 1'b1)
                                      * LIM_W'(NS_PER_MS);
                        win_pos_in  = (req_data.window_ms != '0);
                        count_in    = fill_ff;
                        oldest_in   = full ? widx_ff : '0;
                        ptr_in      = full ? widx_ff : '0;
                        cnt_in      = '0;
                        ev_valid_in = 1'b0;
                        state_in    = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_END: begin
            // Start entry is on the read port now; record stop and duration
            if (dur_new > ever_max_ff) begin
               ever_max_in = dur_new;
            end
            if (dur_new < ever_min_ff) begin
               ever_min_in = dur_new;
            end
            widx_in  = next_ptr(widx_ff);
            fill_in  = full ? fill_ff : fill_ff + 1'b1;
            state_in = ST_IDLE;
         end

         ST_SEARCH: begin
            // Issue one read per cycle, test the entry read in the cycle before
            ptr_in      = next_ptr(ptr_ff);
            cnt_in      = cnt_ff + 1'b1;
            ev_valid_in = 1'b1;
            ev_ptr_in   = ptr_ff;
            ev_cnt_in   = cnt_ff;
            if (ev_valid_ff) begin
               if ((ev_cnt_ff == '0) || hit) begin
                  win_start_in = start_rd;
               end
               if (hit) begin
                  off_in      = ev_cnt_ff;
                  ptr_in      = ev_ptr_ff;
                  cnt_in      = ev_cnt_ff;
                  ev_valid_in = 1'b0;
                  acc_ctrl.clear = 1'b1;
                  state_in    = ST_SUM;
               end else if (ev_last) begin
                  // Nothing in the window: take every sample
                  off_in      = '0;
                  ptr_in      = oldest_ff;
                  cnt_in      = '0;
                  ev_valid_in = 1'b0;
                  acc_ctrl.clear = 1'b1;
                  state_in    = ST_SUM;
               end
            end
         end

         ST_SUM: begin
            ptr_in      = next_ptr(ptr_ff);
            cnt_in      = cnt_ff + 1'b1;
            ev_valid_in = 1'b1;
            ev_ptr_in   = ptr_ff;
            ev_cnt_in   = cnt_ff;
            if (ev_valid_ff) begin
               acc_ctrl.add = 1'b1;
               if (ev_last) begin
                  last_stop_in = hist_rd[2*TIME_W-1:TIME_W];
                  ev_valid_in  = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            rsp_valid_in            = 1'b1;
            rsp_in.has_samples      = 1'b1;
            rsp_in.window_start_ns  = win_start_ff;
            rsp_in.window_stop_ns   = last_stop_ff;
            rsp_in.sum_ns           = acc_sum;
            rsp_in.sample_count     = COUNT_W'(count_ff - off_ff);
            rsp_in.window_max_ns    = acc_max;
            rsp_in.window_min_ns    = acc_min;
            rsp_in.all_time_max_ns  = ever_max_ff;
            rsp_in.all_time_min_ns  = ever_min_ff;
            state_in                = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         widx_ff      <= '0;
         fill_ff      <= '0;
         ever_max_ff  <= '0;
         ever_min_ff  <= '1;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         ever_max_ff  <= ever_max_in;
         ever_min_ff  <= ever_min_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      lim_lo_ff    <= lim_lo_in;
      lim_hi_ff    <= lim_hi_in;
      win_pos_ff   <= win_pos_in;
      count_ff     <= count_in;
      oldest_ff    <= oldest_in;
      ptr_ff       <= ptr_in;
      cnt_ff       <= cnt_in;
      ev_ptr_ff    <= ev_ptr_in;
      ev_cnt_ff    <= ev_cnt_in;
      off_ff       <= off_in;
      win_start_ff <= win_start_in;
      last_stop_ff <= last_stop_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
